/* rtl/core/shs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package shs_pkg;

    typedef logic [31:0] t_word;
    typedef logic [5:0]  t_pos;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam t_pos       LEN_OFFSET = 6'd56;
    localparam t_pos       POS_LAST   = 6'd63;
    localparam t_pos       ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // round engine controls
    typedef struct packed {
        logic start;   // load working vars from chaining value
        logic round;   // one compression round
        logic fold;    // add working vars into chaining value
        logic init;    // restore initial hash
    } t_core_ctl;

    // message window controls
    typedef struct packed {
        logic load_byte;  // shift one byte into the block
        logic step;       // advance the schedule by one word
    } t_sched_ctl;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

`default_nettype wire

/* rtl/core/shs_msg_sched.sv */
`timescale 1ns / 1ps
`default_nettype none

// 64-byte block as a shift line; oldest schedule word sits in the top bits.
module shs_msg_sched (
    input  wire logic                i_clk,
    input  wire shs_pkg::t_sched_ctl i_ctl,
    input  wire logic [7:0]          i_byte,
    output shs_pkg::t_word           o_w
);

    logic [511:0] r_blk;
    logic [511:0] n_blk;
    shs_pkg::t_word w0, w1, w9, w14, s0, s1, w_new;

    assign w0  = r_blk[511:480];
    assign w1  = r_blk[479:448];
    assign w9  = r_blk[223:192];
    assign w14 = r_blk[63:32];

    assign s0 = shs_pkg::rotr(w1, 7) ^ shs_pkg::rotr(w1, 18) ^ (w1 >> 3);
    assign s1 = shs_pkg::rotr(w14, 17) ^ shs_pkg::rotr(w14, 19) ^ (w14 >> 10);
    assign w_new = s1 + w9 + s0 + w0;
    assign o_w = w0;

    always_comb begin
        n_blk = r_blk;
        if (i_ctl.load_byte) begin
            n_blk = {r_blk[503:0], i_byte};
        end else if (i_ctl.step) begin
            n_blk = {r_blk[479:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
    end

endmodule

`default_nettype wire

/* rtl/core/shs_round_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Chaining value plus working variables a..h; one round per cycle while round is set.
module shs_round_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire shs_pkg::t_core_ctl i_ctl,
    input  wire shs_pkg::t_word     i_w,
    input  wire shs_pkg::t_word     i_k,
    output shs_pkg::t_word          o_h [8]
);

    shs_pkg::t_word r_h [8];
    shs_pkg::t_word r_v [8];
    shs_pkg::t_word big0, big1, chs, maj, t1, t2;

    assign big1 = shs_pkg::rotr(r_v[4], 6) ^ shs_pkg::rotr(r_v[4], 11)
                ^ shs_pkg::rotr(r_v[4], 25);
    assign chs  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1   = r_v[7] + big1 + chs + i_k + i_w;
    assign big0 = shs_pkg::rotr(r_v[0], 2) ^ shs_pkg::rotr(r_v[0], 13)
                ^ shs_pkg::rotr(r_v[0], 22);
    assign maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t2   = big0 + maj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_h <= shs_pkg::INIT_HASH;
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_v <= r_h;
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_h = r_h;

endmodule

`default_nettype wire

/* rtl/core/sha256_stream_hasher.sv */
`timescale 1ns / 1ps
`default_nettype none

// SHA-256 over a byte stream. Each input transfer either absorbs one message byte
// (tuser = 0, byte in tdata) or finishes the message (tuser = 1, tdata ignored).
// The byte that fills a 64-byte block starts a compression (one round per cycle in
// the shared round engine) and then a fold of the working variables into the
// chaining value.
// Finish writes the padding one byte per cycle (0x80, zeros, big-endian 64-bit bit
// length) and compresses one block, or two when 56 or more bytes were pending. The
// worst case is 56 pending bytes: 8 pad bytes, a compression and fold, 64 more pad
// bytes and another compression and fold, all before the eight digest words come
// out, word 0 first, each big-endian, the eighth marked by tlast. After the last
// word is loaded into the output register the hasher is re-initialized and takes
// the next message while that word still waits. Bit length wraps modulo 2^64.
// tready is low while busy.
module sha256_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] command: 0 absorb, 1 finish
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic             o_m_axis_tlast    // last_word
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_FOLD  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    shs_pkg::t_pos r_pos, n_pos;          // pending bytes in block
    shs_pkg::t_pos r_rnd, n_rnd;          // round counter
    shs_pkg::t_pos r_len_pos, n_len_pos;  // byte count at finish
    logic [54:0] r_blk_cnt, n_blk_cnt;    // data blocks compressed
    logic r_fin, n_fin;                   // finishing a message
    logic r_pad_first, n_pad_first;       // next pad byte is the 0x80 marker
    logic r_last_blk, n_last_blk;         // current pad block carries the length
    logic [2:0] r_eidx, n_eidx;           // next digest word to emit

    logic r_ov, n_ov;
    shs_pkg::t_word r_oword, n_oword;
    logic [2:0] r_oidx, n_oidx;

    shs_pkg::t_core_ctl  core_ctl;
    shs_pkg::t_sched_ctl sched_ctl;
    logic [7:0] sched_byte, pad_byte;
    logic [63:0] total_bits;
    shs_pkg::t_word w_cur;
    shs_pkg::t_word h_cur [8];
    logic in_xfer, out_xfer;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = r_ov && i_m_axis_tready;

    // message bit length; the block count supplies bits 63:9
    assign total_bits = {r_blk_cnt, r_len_pos, 3'b000};

    always_comb begin
        if (r_pad_first) begin
            pad_byte = shs_pkg::PAD_MARK;
        end else if (r_last_blk && (r_pos >= shs_pkg::LEN_OFFSET)) begin
            pad_byte = total_bits[(6'd63 - {r_pos[2:0], 3'b000}) -: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_rnd       = r_rnd;
        n_len_pos   = r_len_pos;
        n_blk_cnt   = r_blk_cnt;
        n_fin       = r_fin;
        n_pad_first = r_pad_first;
        n_last_blk  = r_last_blk;
        n_eidx      = r_eidx;
        n_ov        = out_xfer ? 1'b0 : r_ov;
        n_oword     = r_oword;
        n_oidx      = r_oidx;
        core_ctl    = '0;
        sched_ctl   = '0;
        sched_byte  = i_s_axis_tdata;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (!i_s_axis_tuser) begin
                        sched_ctl.load_byte = 1'b1;
                        n_pos = r_pos + 6'd1;
                        if (r_pos == shs_pkg::POS_LAST) begin
                            core_ctl.start = 1'b1;
                            n_rnd   = '0;
                            n_state = S_ROUND;
                        end
                    end else begin
                        n_fin       = 1'b1;
                        n_pad_first = 1'b1;
                        n_last_blk  = (r_pos < shs_pkg::LEN_OFFSET);
                        n_len_pos   = r_pos;
                        n_state     = S_PAD;
                    end
                end
            end
            S_PAD: begin
                sched_ctl.load_byte = 1'b1;
                sched_byte  = pad_byte;
                n_pad_first = 1'b0;
                n_pos       = r_pos + 6'd1;
                if (r_pos == shs_pkg::POS_LAST) begin
                    core_ctl.start = 1'b1;
                    n_rnd   = '0;
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                core_ctl.round = 1'b1;
                sched_ctl.step = 1'b1;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == shs_pkg::ROUND_LAST) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                core_ctl.fold = 1'b1;
                if (!r_fin) begin
                    n_blk_cnt = r_blk_cnt + 55'd1;
                    n_state   = S_IDLE;
                end else if (r_last_blk) begin
                    n_eidx  = '0;
                    n_state = S_EMIT;
                end else begin
                    // overflow block done; length goes in a fresh block
                    n_last_blk = 1'b1;
                    n_state    = S_PAD;
                end
            end
            S_EMIT: begin
                if (!r_ov || i_m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_oword = h_cur[r_eidx];
                    n_oidx  = r_eidx;
                    n_eidx  = r_eidx + 3'd1;
                    if (r_eidx == shs_pkg::WORD_LAST) begin
                        core_ctl.init = 1'b1;
                        n_fin     = 1'b0;
                        n_pos     = '0;
                        n_blk_cnt = '0;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_rnd       <= '0;
            r_len_pos   <= '0;
            r_blk_cnt   <= '0;
            r_fin       <= 1'b0;
            r_pad_first <= 1'b0;
            r_last_blk  <= 1'b0;
            r_eidx      <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_rnd       <= n_rnd;
            r_len_pos   <= n_len_pos;
            r_blk_cnt   <= n_blk_cnt;
            r_fin       <= n_fin;
            r_pad_first <= n_pad_first;
            r_last_blk  <= n_last_blk;
            r_eidx      <= n_eidx;
            r_ov        <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oword <= n_oword;
        r_oidx  <= n_oidx;
    end

    shs_msg_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (sched_ctl),
        .i_byte (sched_byte),
        .o_w    (w_cur)
    );

    shs_round_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_w     (w_cur),
        .i_k     (shs_pkg::ROUND_K[r_rnd]),
        .o_h     (h_cur)
    );

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {5'b00000, r_oidx, r_oword};
    assign o_m_axis_tlast  = (r_oidx == shs_pkg::WORD_LAST);

endmodule

`default_nettype wire

/* rtl/core/shs_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module shs_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tlast
);

    // tlast marks exactly the eighth word
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata[34:32] == 3'd7)))
        else $error("tlast does not match word index");

    // stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    // input stays closed while a digest word other than the last is on the output
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[34:32] != 3'd7) |-> !o_s_axis_tready)
        else $error("input open during digest output");

    // finish makes the block busy
    a_fin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser |=> !o_s_axis_tready)
        else $error("ready after finish transfer");

    // first cycle out of reset: idle and empty
    a_reset_idle: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> o_s_axis_tready && !o_m_axis_tvalid)
        else $error("not idle after reset");

endmodule

bind sha256_stream_hasher shs_chk u_shs_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire
